### rtl/mwca_pkg.sv
// ----------------------------------------------------------------------------
// mwca_pkg
// Shared types and constants of the mapped window cache with aging.
// ----------------------------------------------------------------------------
`default_nettype none

package mwca_pkg;

    localparam int WINDOWS_DEF      = 8;
    localparam int WINDOW_BYTES_DEF = 1048576;

    localparam int ADDR_W     = 32;
    localparam int PSIZE_W    = 15;
    localparam int PINS_W     = 8;
    localparam int ACT_W      = 16;
    localparam int SLOT_W     = 3;
    localparam int OFF_W      = 20;
    localparam int AGE_SHIFT  = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST = 15'd1024;

    localparam logic ACT_ACCESS  = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BASE = 1'b1;

    typedef enum logic [2:0] {
        OC_HIT       = 3'd0,
        OC_FIRST_MAP = 3'd1,
        OC_REMAP     = 3'd2,
        OC_NO_VICTIM = 3'd3,
        OC_RELEASED  = 3'd4
    } t_outcome;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [PINS_W-1:0] pins;
        logic [ACT_W-1:0]  act;
    } t_entry;

endpackage

`default_nettype wire

### rtl/mapped_window_cache_aging_core.sv
// ----------------------------------------------------------------------------
// mapped_window_cache_aging_core
// Fully associative file window cache with least-activity replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item: an access of a
//   page or a release of a pinned slot. Output channel (o_out_valid /
//   i_out_stall) returns exactly one result item per input item.
//   Config port (i_cfg_valid / o_cfg_ready) writes page_size (index 0) and
//   page_base (index 1); ready is always high, write only while idle.
// Steps (N = WINDOWS), the per-slot state lives in one RAM read once a cycle:
//   access hit or no victim : offset multiply, N-entry scan, decide, finish
//   access miss with victim : scan plus aging write-back pass over all N entries
//   release                 : read, modify, write of one entry, finish
//   One item is in work at a time; o_in_stall is high while busy.
// Reset: all windows invalid at once through per-slot valid flops, no clear
//   pass; registers return to page_size 1024, page_base 0.
// Stall: a finished result waits in the output register; the next item is
//   accepted meanwhile and only its own result waits for the register.
// ----------------------------------------------------------------------------
`default_nettype none

module mapped_window_cache_aging_core #(
    parameter int WINDOWS      = mwca_pkg::WINDOWS_DEF,
    parameter int WINDOW_BYTES = mwca_pkg::WINDOW_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,

    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_action,
    input  wire logic [mwca_pkg::ADDR_W-1:0]     i_page_number,
    input  wire logic [mwca_pkg::SLOT_W-1:0]     i_release_slot,

    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [2:0]                           o_outcome,
    output logic [mwca_pkg::SLOT_W-1:0]          o_slot,
    output logic [mwca_pkg::ADDR_W-1:0]          o_window_base,
    output logic [mwca_pkg::OFF_W-1:0]           o_offset_in_window,

    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [mwca_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mwca_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import mwca_pkg::*;

    localparam int IW = $clog2(WINDOWS);
    localparam int CW = $clog2(WINDOWS + 1);
    localparam logic [ADDR_W-1:0] WB_MASK = ADDR_W'(WINDOW_BYTES - 1);
    localparam logic [CW-1:0] CNT_LAST = CW'(WINDOWS);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SCAN, S_DECIDE, S_AGE, S_REL_RD, S_REL_WR, S_FINISH
    } t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [ADDR_W-1:0]    r_pdiff, n_pdiff;
    logic [ADDR_W-1:0]    r_offset, n_offset;
    logic [PSIZE_W-1:0]   r_page_size, n_page_size;
    logic [ADDR_W-1:0]    r_page_base, n_page_base;
    logic [WINDOWS-1:0]   r_valid, n_valid;
    logic [IW-1:0]        r_rdaddr, n_rdaddr;
    logic                 r_hit, n_hit;
    logic [IW-1:0]        r_hit_idx, n_hit_idx;
    t_entry               r_hit_ent, n_hit_ent;
    logic                 r_vic_found, n_vic_found;
    logic [IW-1:0]        r_vic_idx, n_vic_idx;
    logic [ACT_W-1:0]     r_vic_act, n_vic_act;
    logic                 r_vic_was_valid, n_vic_was_valid;
    logic [IW-1:0]        r_rel_idx, n_rel_idx;
    logic [SLOT_W-1:0]    r_rel_slot, n_rel_slot;
    t_outcome             r_res_outcome, n_res_outcome;
    logic [SLOT_W-1:0]    r_res_slot, n_res_slot;
    logic [ADDR_W-1:0]    r_res_base, n_res_base;
    logic [OFF_W-1:0]     r_res_off, n_res_off;
    logic                 r_out_valid, n_out_valid;
    t_outcome             r_out_outcome, n_out_outcome;
    logic [SLOT_W-1:0]    r_out_slot, n_out_slot;
    logic [ADDR_W-1:0]    r_out_base, n_out_base;
    logic [OFF_W-1:0]     r_out_off, n_out_off;

    logic                 w_we;
    logic [IW-1:0]        w_waddr, w_raddr;
    t_entry               w_wdata, w_rdata, w_rd_ent;
    logic [ADDR_W-1:0]    w_section, w_diff, w_hit_diff, w_sec_off;
    logic                 w_in_win, w_accept, w_out_free, w_rel_ok;
    logic [31:0]          w_rel_ext, w_hit_ext, w_vic_ext;

    mwca_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (WINDOWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // entries of slots whose valid flop is clear read as zero
    assign w_rd_ent   = r_valid[r_rdaddr] ? w_rdata : '0;
    assign w_section  = r_offset & ~WB_MASK;
    assign w_diff     = r_offset - w_rd_ent.base;
    assign w_in_win   = (w_diff & ~WB_MASK) == '0;
    assign w_hit_diff = r_offset - r_hit_ent.base;
    assign w_sec_off  = r_offset - w_section;
    assign w_rel_ext  = 32'(i_release_slot);
    assign w_rel_ok   = w_rel_ext < 32'(WINDOWS);
    assign w_hit_ext  = 32'(r_hit_idx);
    assign w_vic_ext  = 32'(r_vic_idx);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        n_pdiff         = r_pdiff;
        n_offset        = r_offset;
        n_page_size     = r_page_size;
        n_page_base     = r_page_base;
        n_valid         = r_valid;
        n_rdaddr        = w_raddr;
        n_hit           = r_hit;
        n_hit_idx       = r_hit_idx;
        n_hit_ent       = r_hit_ent;
        n_vic_found     = r_vic_found;
        n_vic_idx       = r_vic_idx;
        n_vic_act       = r_vic_act;
        n_vic_was_valid = r_vic_was_valid;
        n_rel_idx       = r_rel_idx;
        n_rel_slot      = r_rel_slot;
        n_res_outcome   = r_res_outcome;
        n_res_slot      = r_res_slot;
        n_res_base      = r_res_base;
        n_res_off       = r_res_off;
        n_out_valid     = r_out_valid && i_out_stall;
        n_out_outcome   = r_out_outcome;
        n_out_slot      = r_out_slot;
        n_out_base      = r_out_base;
        n_out_off       = r_out_off;
        w_we            = 1'b0;
        w_waddr         = r_rdaddr;
        w_wdata         = w_rd_ent;
        w_raddr         = '0;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PAGE_SIZE: n_page_size = i_cfg_data[PSIZE_W-1:0];
                CFG_PAGE_BASE: n_page_base = i_cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_rel_slot = i_release_slot;
                    n_rel_idx  = w_rel_ext[IW-1:0];
                    if (i_action == ACT_RELEASE) begin
                        if (w_rel_ok) begin
                            n_state = S_REL_RD;
                        end else begin
                            n_res_outcome = OC_RELEASED;
                            n_res_slot    = i_release_slot;
                            n_res_base    = '0;
                            n_res_off     = '0;
                            n_state       = S_FINISH;
                        end
                    end else begin
                        n_pdiff     = i_page_number - r_page_base;
                        n_hit       = 1'b0;
                        n_vic_found = 1'b0;
                        n_state     = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_offset = r_pdiff * ADDR_W'(r_page_size);
                n_cnt    = '0;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                w_raddr = (r_cnt < CNT_LAST) ? r_cnt[IW-1:0] : '0;
                if (r_cnt != '0) begin
                    if (!r_hit && r_valid[r_rdaddr] && w_in_win) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_rdaddr;
                        n_hit_ent = w_rd_ent;
                    end
                    if (w_rd_ent.pins == '0 &&
                        (!r_vic_found || w_rd_ent.act < r_vic_act)) begin
                        n_vic_found     = 1'b1;
                        n_vic_idx       = r_rdaddr;
                        n_vic_act       = w_rd_ent.act;
                        n_vic_was_valid = r_valid[r_rdaddr];
                    end
                end
                if (r_cnt == CNT_LAST) begin
                    n_state = S_DECIDE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DECIDE: begin
                if (r_hit) begin
                    w_we         = 1'b1;
                    w_waddr      = r_hit_idx;
                    w_wdata      = r_hit_ent;
                    if (r_hit_ent.pins != '1) w_wdata.pins = r_hit_ent.pins + 1'b1;
                    if (r_hit_ent.act != '1)  w_wdata.act  = r_hit_ent.act + 1'b1;
                    n_res_outcome = OC_HIT;
                    n_res_slot    = w_hit_ext[SLOT_W-1:0];
                    n_res_base    = r_hit_ent.base;
                    n_res_off     = w_hit_diff[OFF_W-1:0];
                    n_state       = S_FINISH;
                end else if (r_vic_found) begin
                    n_res_outcome = r_vic_was_valid ? OC_REMAP : OC_FIRST_MAP;
                    n_res_slot    = w_vic_ext[SLOT_W-1:0];
                    n_res_base    = w_section;
                    n_res_off     = w_sec_off[OFF_W-1:0];
                    n_cnt         = '0;
                    n_state       = S_AGE;
                end else begin
                    n_res_outcome = OC_NO_VICTIM;
                    n_res_slot    = '0;
                    n_res_base    = '0;
                    n_res_off     = '0;
                    n_state       = S_FINISH;
                end
            end
            S_AGE: begin
                w_raddr = (r_cnt < CNT_LAST) ? r_cnt[IW-1:0] : '0;
                if (r_cnt != '0) begin
                    w_we    = 1'b1;
                    w_waddr = r_rdaddr;
                    if (r_rdaddr == r_vic_idx) begin
                        w_wdata.base = w_section;
                        w_wdata.pins = PINS_W'(1);
                        w_wdata.act  = ACT_W'(1);
                    end else begin
                        w_wdata.act = w_rd_ent.act >> AGE_SHIFT;
                    end
                end
                if (r_cnt == CNT_LAST) begin
                    n_valid[r_vic_idx] = 1'b1;
                    n_state            = S_FINISH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_REL_RD: begin
                w_raddr = r_rel_idx;
                n_state = S_REL_WR;
            end
            S_REL_WR: begin
                w_we    = 1'b1;
                w_waddr = r_rdaddr;
                if (w_rd_ent.pins != '0) w_wdata.pins = w_rd_ent.pins - 1'b1;
                n_res_outcome = OC_RELEASED;
                n_res_slot    = r_rel_slot;
                n_res_base    = w_rd_ent.base;
                n_res_off     = '0;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_outcome = r_res_outcome;
                    n_out_slot    = r_res_slot;
                    n_out_base    = r_res_base;
                    n_out_off     = r_res_off;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_page_size <= PAGE_SIZE_RST;
            r_page_base <= '0;
            r_hit       <= 1'b0;
            r_vic_found <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            r_page_size <= n_page_size;
            r_page_base <= n_page_base;
            r_hit       <= n_hit;
            r_vic_found <= n_vic_found;
        end
        r_pdiff         <= n_pdiff;
        r_offset        <= n_offset;
        r_rdaddr        <= n_rdaddr;
        r_hit_idx       <= n_hit_idx;
        r_hit_ent       <= n_hit_ent;
        r_vic_idx       <= n_vic_idx;
        r_vic_act       <= n_vic_act;
        r_vic_was_valid <= n_vic_was_valid;
        r_rel_idx       <= n_rel_idx;
        r_rel_slot      <= n_rel_slot;
        r_res_outcome   <= n_res_outcome;
        r_res_slot      <= n_res_slot;
        r_res_base      <= n_res_base;
        r_res_off       <= n_res_off;
        r_out_outcome   <= n_out_outcome;
        r_out_slot      <= n_out_slot;
        r_out_base      <= n_out_base;
        r_out_off       <= n_out_off;
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_outcome          = r_out_outcome;
    assign o_slot             = r_out_slot;
    assign o_window_base      = r_out_base;
    assign o_offset_in_window = r_out_off;
    assign o_cfg_ready        = 1'b1;

endmodule

`default_nettype wire

### rtl/mwca_ram.sv
// ----------------------------------------------------------------------------
// mwca_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mwca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/mwca_checker.sv
// ----------------------------------------------------------------------------
// mwca_checker
// Port-level assertions for the mapped window cache, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mwca_checker #(
    parameter int WINDOW_BYTES = mwca_pkg::WINDOW_BYTES_DEF
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_stall,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [2:0]                  o_outcome,
    input wire logic [mwca_pkg::SLOT_W-1:0] o_slot,
    input wire logic [mwca_pkg::ADDR_W-1:0] o_window_base,
    input wire logic [mwca_pkg::OFF_W-1:0]  o_offset_in_window
);

    import mwca_pkg::*;

    localparam int WB_BITS = $clog2(WINDOW_BYTES);

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while an item is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_outcome) &&
        $stable(o_slot) && $stable(o_window_base) && $stable(o_offset_in_window))
        else $error("stalled result item changed");

    a_no_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_outcome == OC_NO_VICTIM |->
        o_slot == '0 && o_window_base == '0 && o_offset_in_window == '0)
        else $error("no-victim result carries data");

    a_base_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_outcome == OC_HIT || o_outcome == OC_FIRST_MAP ||
        o_outcome == OC_REMAP) |-> o_window_base[WB_BITS-1:0] == '0)
        else $error("window base not aligned");

endmodule

bind mapped_window_cache_aging_core mwca_checker #(
    .WINDOW_BYTES (WINDOW_BYTES)
) u_mwca_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_outcome          (o_outcome),
    .o_slot             (o_slot),
    .o_window_base      (o_window_base),
    .o_offset_in_window (o_offset_in_window)
);

`default_nettype wire

### sim/mapped_window_cache_aging_core_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mapped_window_cache_aging_core_check
// Watches the config, input and output channels of the window cache. It
// keeps its own copy of the window table and registers, works out the result
// of every accepted item and compares each accepted result with the oldest
// one still pending. It hands the mismatch and pending counts to the test top.
// ----------------------------------------------------------------------------
module mapped_window_cache_aging_core_check
    import mwca_pkg::*;
#(
    parameter int WINDOWS      = WINDOWS_DEF,
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic                  i_action,
    input  logic [ADDR_W-1:0]     i_page_number,
    input  logic [SLOT_W-1:0]     i_release_slot,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [2:0]            i_outcome,
    input  logic [SLOT_W-1:0]     i_slot,
    input  logic [ADDR_W-1:0]     i_window_base,
    input  logic [OFF_W-1:0]      i_offset_in_window,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending
);

    localparam logic [ADDR_W-1:0] WIN_SPAN = WINDOW_BYTES;

    typedef struct packed {
        t_outcome            outcome;
        logic [SLOT_W-1:0]   slot;
        logic [ADDR_W-1:0]   base;
        logic [OFF_W-1:0]    off;
    } t_window_result;

    t_window_result     pending_results [$];

    logic               win_valid [WINDOWS];
    logic [ADDR_W-1:0]  win_base  [WINDOWS];
    logic [PINS_W-1:0]  win_pins  [WINDOWS];
    logic [ACT_W-1:0]   win_act   [WINDOWS];
    logic [PSIZE_W-1:0] cur_page_size;
    logic [ADDR_W-1:0]  cur_page_base;
    int                 mismatch_count = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h",
                 $time, what, want, got);
    endtask

    task automatic touch_window(input int s);
        if (win_pins[s] != {PINS_W{1'b1}})
            win_pins[s] = win_pins[s] + 1'b1;
        if (win_act[s] != {ACT_W{1'b1}})
            win_act[s] = win_act[s] + 1'b1;
    endtask

    task automatic unpin_slot(input logic [SLOT_W-1:0] rslot);
        t_window_result r;
        int             idx;
        idx       = int'(rslot);
        r.outcome = OC_RELEASED;
        r.slot    = rslot;
        r.off     = '0;
        r.base    = '0;
        if (idx < WINDOWS) begin
            if (win_pins[idx] != '0)
                win_pins[idx] = win_pins[idx] - 1'b1;
            r.base = win_base[idx];
        end
        pending_results.push_back(r);
    endtask

    task automatic map_page(input logic [ADDR_W-1:0] page);
        t_window_result    r;
        logic [ADDR_W-1:0] scale;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] section;
        logic [ADDR_W-1:0] delta;
        int                hit;
        int                victim;
        int                i;
        scale                = '0;
        scale[PSIZE_W-1:0]   = cur_page_size;
        offset               = (page - cur_page_base) * scale;
        section              = offset - (offset % WIN_SPAN);
        hit                  = -1;
        for (i = 0; i < WINDOWS; i++) begin
            delta = offset - win_base[i];
            if (hit < 0 && win_valid[i] && delta < WIN_SPAN)
                hit = i;
        end
        if (hit >= 0) begin
            touch_window(hit);
            delta     = offset - win_base[hit];
            r.outcome = OC_HIT;
            r.slot    = hit[SLOT_W-1:0];
            r.base    = win_base[hit];
            r.off     = delta[OFF_W-1:0];
        end else begin
            victim = -1;
            for (i = 0; i < WINDOWS; i++) begin
                if (win_pins[i] == '0 && (victim < 0 || win_act[i] < win_act[victim]))
                    victim = i;
            end
            if (victim < 0) begin
                r.outcome = OC_NO_VICTIM;
                r.slot    = '0;
                r.base    = '0;
                r.off     = '0;
            end else begin
                r.outcome = win_valid[victim] ? OC_REMAP : OC_FIRST_MAP;
                for (i = 0; i < WINDOWS; i++)
                    win_act[i] = win_act[i] >> AGE_SHIFT;
                win_valid[victim] = 1'b1;
                win_base[victim]  = section;
                win_act[victim]   = '0;
                touch_window(victim);
                delta  = offset - section;
                r.slot = victim[SLOT_W-1:0];
                r.base = section;
                r.off  = delta[OFF_W-1:0];
            end
        end
        pending_results.push_back(r);
    endtask

    task automatic check_result();
        t_window_result want;
        if (pending_results.size() == 0) begin
            flag_mismatch("result with none pending, outcome", 32'd0, 32'(i_outcome));
        end else begin
            want = pending_results.pop_front();
            if (i_outcome !== want.outcome)
                flag_mismatch("outcome", 32'(want.outcome), 32'(i_outcome));
            if (i_slot !== want.slot)
                flag_mismatch("slot", 32'(want.slot), 32'(i_slot));
            if (i_window_base !== want.base)
                flag_mismatch("window_base", want.base, i_window_base);
            if (i_offset_in_window !== want.off)
                flag_mismatch("offset_in_window", 32'(want.off),
                              32'(i_offset_in_window));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOWS; i++) begin
                win_valid[i] = 1'b0;
                win_base[i]  = '0;
                win_pins[i]  = '0;
                win_act[i]   = '0;
            end
            cur_page_size = PAGE_SIZE_RST;
            cur_page_base = '0;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PAGE_SIZE: cur_page_size = i_cfg_data[PSIZE_W-1:0];
                    CFG_PAGE_BASE: cur_page_base = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall)
                check_result();
            if (i_in_valid && !i_in_stall) begin
                if (i_action == ACT_RELEASE)
                    unpin_slot(i_release_slot);
                else
                    map_page(i_page_number);
            end
        end
        o_pending    <= pending_results.size();
        o_mismatches <= mismatch_count;
    end

endmodule

### sim/mapped_window_cache_aging_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mapped_window_cache_aging_core_test
// Test top of the window cache: directed accesses and releases covering first
// maps, hits, remaps, full pinning and pin saturation, then random traffic
// around a pool of page anchors under several page size and base settings,
// with random idle bursts on both channels. The checker does the comparing.
// ----------------------------------------------------------------------------
module mapped_window_cache_aging_core_test;
    import mwca_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  i_action       = ACT_ACCESS;
    logic [ADDR_W-1:0]     i_page_number  = '0;
    logic [SLOT_W-1:0]     i_release_slot = '0;
    logic                  i_out_stall    = 1'b0;
    logic                  i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = CFG_PAGE_SIZE;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [2:0]            o_outcome;
    logic [SLOT_W-1:0]     o_slot;
    logic [ADDR_W-1:0]     o_window_base;
    logic [OFF_W-1:0]      o_offset_in_window;
    logic                  o_cfg_ready;

    int                    mismatches;
    int                    pending;
    logic                  idle_on     = 1'b1;
    int                    stall_left  = 0;
    int                    idle_cycles = 0;
    logic [ADDR_W-1:0]     anchors [12];

    mapped_window_cache_aging_core u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_action           (i_action),
        .i_page_number      (i_page_number),
        .i_release_slot     (i_release_slot),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_outcome          (o_outcome),
        .o_slot             (o_slot),
        .o_window_base      (o_window_base),
        .o_offset_in_window (o_offset_in_window),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    mapped_window_cache_aging_core_check u_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_action           (i_action),
        .i_page_number      (i_page_number),
        .i_release_slot     (i_release_slot),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_outcome          (o_outcome),
        .i_slot             (o_slot),
        .i_window_base      (o_window_base),
        .i_offset_in_window (o_offset_in_window),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_mismatches       (mismatches),
        .o_pending          (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // output side back-pressure bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || !idle_on) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1)
                i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 11) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(1, 16);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("** mapped_window_cache_aging_core: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic act, input logic [ADDR_W-1:0] page,
                             input logic [SLOT_W-1:0] rslot);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_page_number  <= page;
        i_release_slot <= rslot;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic access_page(input logic [ADDR_W-1:0] page);
        send_item(ACT_ACCESS, page, SLOT_W'($urandom_range(0, 7)));
    endtask

    task automatic release_slot(input logic [SLOT_W-1:0] rslot);
        send_item(ACT_RELEASE, $urandom, rslot);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic set_window_map(input logic [CFG_DATA_W-1:0] size,
                                  input logic [CFG_DATA_W-1:0] base);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_PAGE_SIZE;
        i_cfg_data  <= size;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_PAGE_BASE;
        i_cfg_data  <= base;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_traffic(input int count, input int release_pct);
        int j;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 39) == 0)
                drain_results();
            if ($urandom_range(0, 99) < release_pct) begin
                release_slot(SLOT_W'($urandom_range(0, 7)));
            end else if ($urandom_range(0, 9) == 0) begin
                access_page($urandom);
            end else begin
                j = $urandom_range(0, 11);
                if ($urandom_range(0, 15) == 0)
                    anchors[j] = $urandom;
                access_page(anchors[j] + $urandom_range(0, 63));
            end
        end
    endtask

    initial begin
        for (int k = 0; k < 12; k++)
            anchors[k] = $urandom;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, fill all slots, then full pinning and remaps
        release_slot(0);
        release_slot(7);
        access_page(32'd0);
        access_page(32'd0);
        access_page(32'd1023);
        access_page(32'd1024);
        access_page(32'hFFFF_FFFF);
        access_page(32'd2048);
        access_page(32'd3072);
        access_page(32'd4096);
        access_page(32'd5120);
        access_page(32'd6144);
        access_page(32'd8192);
        release_slot(1);
        access_page(32'd9216);
        release_slot(3);
        release_slot(4);
        access_page(32'd10240);
        access_page(32'h8000_0000);
        release_slot(4);
        access_page(32'h7FFF_FFFF);
        drain_results();
        set_window_map(32'd0, 32'hFFFF_FFFF);
        access_page(32'd123);
        access_page(32'hFFFF_FFFF);
        drain_results();

        // pin count saturation on the window at offset zero
        set_window_map(32'd1024, 32'd0);
        idle_on <= 1'b0;
        for (int k = 0; k < 260; k++)
            access_page(32'd5);
        release_slot(0);
        idle_on <= 1'b1;
        drain_results();

        set_window_map(32'd16384, 32'hFFFF_FFFF);
        random_traffic(30, 40);
        drain_results();
        set_window_map(32'd1024, $urandom);
        random_traffic(30, 30);
        drain_results();
        set_window_map(($urandom & 32'hFFFF_8000) | 32'h0000_7FFF, $urandom);
        random_traffic(25, 50);
        drain_results();
        set_window_map($urandom_range(1024, 16384), $urandom);
        random_traffic(30, 45);
        drain_results();
        set_window_map(32'd1, 32'd0);
        random_traffic(20, 40);
        drain_results();
        set_window_map(32'd4096, $urandom);
        idle_on <= 1'b0;
        random_traffic(30, 40);

        drain_results();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("** mapped_window_cache_aging_core: PASSED **");
        else
            $display("** mapped_window_cache_aging_core: FAILED **");
        $finish;
    end

endmodule
